// ===== rtl/fbdp_pkg.sv =====
// fbdp_pkg: shared constants, types and the arctangent table for the
// fft bin to dB and phase converter. no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbdp_pkg;

  localparam int INPUT_BITS_DEF    = 24;
  localparam int MAX_LOG2_SIZE_DEF = 16;
  localparam int CORDIC_STEPS      = 20;
  localparam int LOG_STEPS         = 16;
  localparam int PRESHIFT          = 20;
  localparam int MW                = 31;   // Q30 mantissa in [1,2)
  localparam int FW                = 16;   // log2 fraction bits
  localparam int ZW                = 25;   // cordic angle accumulator
  localparam int CFG_W             = 5;
  localparam int OUT_W             = 17;
  localparam int DB_PER_OCT_Q16    = 197283;
  localparam int LEVEL_MIN         = -65536;
  localparam int LEVEL_MAX         = 65535;
  localparam int PHASE_HALF        = 46080;
  localparam int Z_MAX             = 5898240;
  localparam logic [CFG_W-1:0] LOG2_SIZE_RESET = 5'd10;

  // per-request sideband carried alongside the data pipes
  typedef struct packed {
    logic zero;
    logic re_neg;
    logic im_neg;
  } side_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fbdp_log_cell.sv =====
// fbdp_log_cell: one squaring step of the log2 fraction chain.
// depends on fbdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbdp_log_cell (
  input  wire logic                      clk,
  input  wire logic [fbdp_pkg::MW-1:0]   m_i,
  input  wire logic [fbdp_pkg::FW-1:0]   frac_i,
  output logic      [fbdp_pkg::MW-1:0]   m_o,
  output logic      [fbdp_pkg::FW-1:0]   frac_o
);

  logic [2*fbdp_pkg::MW-1:0] sq;
  logic [fbdp_pkg::MW:0]     t;
  logic [fbdp_pkg::MW-1:0]   m_nxt;
  logic [fbdp_pkg::FW-1:0]   frac_nxt;
  logic [fbdp_pkg::MW-1:0]   m_r;
  logic [fbdp_pkg::FW-1:0]   frac_r;

  // square, drop 30 fraction bits, renormalize when it reaches two
  always_comb begin
    sq       = m_i * m_i;
    t        = sq[2*fbdp_pkg::MW-1:fbdp_pkg::MW-1];
    m_nxt    = t[fbdp_pkg::MW] ? t[fbdp_pkg::MW:1] : t[fbdp_pkg::MW-1:0];
    frac_nxt = {frac_i[fbdp_pkg::FW-2:0], t[fbdp_pkg::MW]};
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
  end

  assign m_o    = m_r;
  assign frac_o = frac_r;

endmodule
`default_nettype wire

// ===== rtl/fbdp_cordic_cell.sv =====
// fbdp_cordic_cell: one vectoring cordic rotation with a fixed shift.
// depends on fbdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbdp_cordic_cell #(
  parameter int CW   = 47,
  parameter int STEP = 0
) (
  input  wire logic                            clk,
  input  wire logic signed [CW-1:0]            x_i,
  input  wire logic signed [CW-1:0]            y_i,
  input  wire logic signed [fbdp_pkg::ZW-1:0]  z_i,
  output logic      signed [CW-1:0]            x_o,
  output logic      signed [CW-1:0]            y_o,
  output logic      signed [fbdp_pkg::ZW-1:0]  z_o
);

  logic signed [CW-1:0]           xs, ys, x_nxt, y_nxt;
  logic signed [fbdp_pkg::ZW-1:0] ang, z_nxt;
  logic signed [CW-1:0]           x_r, y_r;
  logic signed [fbdp_pkg::ZW-1:0] z_r;

  // shifts truncate toward zero, rotate toward y = 0
  always_comb begin
    xs  = x_i[CW-1] ? -((-x_i) >>> STEP) : (x_i >>> STEP);
    ys  = y_i[CW-1] ? -((-y_i) >>> STEP) : (y_i >>> STEP);
    ang = fbdp_pkg::ZW'(fbdp_pkg::atan_q16(STEP));
    if (!y_i[CW-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ang;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ang;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

// ===== rtl/fft_bin_to_db_and_phase.sv =====
// fft_bin_to_db_and_phase: fft bin to level in 1/256 dB and phase in 1/256 degree.
// depends on fbdp_pkg, fbdp_log_cell, fbdp_cordic_cell.
//
//   channel   ports                                    handshake
//   input     in_real_part, in_imag_part               start, busy (always low)
//   result    out_level_db, out_phase_deg,
//             out_zero_magnitude                       out_strobe, one cycle
//   config    cfg_data                                 cfg_we
//
// one request per cycle. the result path is the input register, the 20-cell
// cordic row, run in step with the squaring, leading-one, normalize and 16-cell
// log2 row, and two output stages. reset clears the pipe valids and loads log2
// size 10; no result is lost to stalls because there are none: the receiver must
// take every strobe, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none
module fft_bin_to_db_and_phase #(
  parameter int INPUT_BITS    = fbdp_pkg::INPUT_BITS_DEF,
  parameter int MAX_LOG2_SIZE = fbdp_pkg::MAX_LOG2_SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [INPUT_BITS-1:0]      in_real_part,
  input  wire logic signed [INPUT_BITS-1:0]      in_imag_part,
  output logic                                   out_strobe,
  output logic signed [fbdp_pkg::OUT_W-1:0]      out_level_db,
  output logic signed [fbdp_pkg::OUT_W-1:0]      out_phase_deg,
  output logic                                   out_zero_magnitude,
  input  wire logic                              cfg_we,
  input  wire logic [fbdp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int N     = INPUT_BITS;
  localparam int PW    = 2 * N;
  localparam int EW    = $clog2(PW);
  localparam int KW    = $clog2(MAX_LOG2_SIZE + 1);
  localparam int DW    = ((EW > KW) ? EW : KW) + 1;
  localparam int LQW   = DW + fbdp_pkg::FW;
  localparam int PRW   = LQW + 19;
  localparam int CW    = N + fbdp_pkg::PRESHIFT + 3;
  localparam int NC    = fbdp_pkg::CORDIC_STEPS;
  localparam int NL    = fbdp_pkg::LOG_STEPS;
  localparam int DEPTH = NC + 2;   // sideband stages 0 .. NC+1
  localparam int OW    = fbdp_pkg::OUT_W;
  localparam int MW    = fbdp_pkg::MW;
  localparam int FW    = fbdp_pkg::FW;
  localparam int ZW    = fbdp_pkg::ZW;

  logic [fbdp_pkg::CFG_W-1:0] cfg_r;
  logic [DEPTH:0]             vld_r;
  fbdp_pkg::side_t            side_r [DEPTH];
  logic [KW-1:0]              k_r    [DEPTH];
  logic [EW-1:0]              e_d_r  [NL];

  logic signed [N-1:0] re_r, im_r;
  logic [N-1:0]        ax, ay;
  logic [PW-1:0]       sqx_r, sqy_r, p_r, p3_r;
  logic [EW-1:0]       e_nxt, e3_r, e4_r;
  logic [PW+MW-1:0]    nt;
  logic [MW-1:0]       m4_r;
  logic                accept;
  logic [KW-1:0]       k_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= fbdp_pkg::LOG2_SIZE_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  // request valid pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DEPTH-1:0], accept};
    end
  end

  // sideband line: zero flag, signs and clamped size
  always_comb begin
    if (int'(cfg_r) > MAX_LOG2_SIZE) k_nxt = KW'(MAX_LOG2_SIZE);
    else                             k_nxt = KW'(cfg_r);
  end

  always_ff @(posedge clk) begin
    re_r             <= in_real_part;
    im_r             <= in_imag_part;
    side_r[0].zero   <= (in_real_part == '0) && (in_imag_part == '0);
    side_r[0].re_neg <= in_real_part[N-1];
    side_r[0].im_neg <= in_imag_part[N-1];
    k_r[0]           <= k_nxt;
    for (int j = 1; j < DEPTH; j++) begin
      side_r[j] <= side_r[j-1];
      k_r[j]    <= k_r[j-1];
    end
  end

  // magnitudes of both parts
  assign ax = re_r[N-1] ? N'(-re_r) : N'(re_r);
  assign ay = im_r[N-1] ? N'(-im_r) : N'(im_r);

  // power, leading one, normalization to Q30
  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (p_r[i]) e_nxt = EW'(i);
    end
  end

  always_comb begin
    if (int'(e3_r) >= 30) nt = {{MW{1'b0}}, p3_r} >> (int'(e3_r) - 30);
    else                  nt = {{MW{1'b0}}, p3_r} << (30 - int'(e3_r));
  end

  always_ff @(posedge clk) begin
    sqx_r <= ax * ax;
    sqy_r <= ay * ay;
    p_r   <= sqx_r + sqy_r;
    p3_r  <= p_r;
    e3_r  <= e_nxt;
    m4_r  <= nt[MW-1:0];
    e4_r  <= e3_r;
    e_d_r[0] <= e4_r;
    for (int j = 1; j < NL; j++) e_d_r[j] <= e_d_r[j-1];
  end

  // log2 fraction row
  logic [MW-1:0] m_w    [NL+1];
  logic [FW-1:0] frac_w [NL+1];
  assign m_w[0]    = m4_r;
  assign frac_w[0] = '0;

  for (genvar g = 0; g < NL; g++) begin : g_log
    fbdp_log_cell u_cell (
      .clk    (clk),
      .m_i    (m_w[g]),
      .frac_i (frac_w[g]),
      .m_o    (m_w[g+1]),
      .frac_o (frac_w[g+1])
    );
  end

  // cordic row
  logic signed [CW-1:0] x_w [NC+1];
  logic signed [CW-1:0] y_w [NC+1];
  logic signed [ZW-1:0] z_w [NC+1];
  assign x_w[0] = $signed(CW'(ax) << fbdp_pkg::PRESHIFT);
  assign y_w[0] = $signed(CW'(ay) << fbdp_pkg::PRESHIFT);
  assign z_w[0] = '0;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    fbdp_cordic_cell #(.CW(CW), .STEP(g)) u_cell (
      .clk (clk),
      .x_i (x_w[g]),
      .y_i (y_w[g]),
      .z_i (z_w[g]),
      .x_o (x_w[g+1]),
      .y_o (y_w[g+1]),
      .z_o (z_w[g+1])
    );
  end

  // scale log2 to dB, finish the angle
  logic signed [DW-1:0]  diff;
  logic signed [LQW-1:0] lq;
  logic signed [PRW-1:0] prod_r, rsum, lvl;
  logic signed [ZW-1:0]  zc;
  logic [14:0]           ph15;
  logic signed [OW-1:0]  ph_mir, ph_nxt, ph_r, lvl_nxt;
  logic signed [PRW-1:0] lim_hi, lim_lo;

  always_comb begin
    diff = $signed(DW'(e_d_r[NL-1])) - $signed(DW'(k_r[NC]));
    lq   = $signed({diff, frac_w[NL]});
    if (z_w[NC] < 0)                     zc = '0;
    else if (z_w[NC] > ZW'(fbdp_pkg::Z_MAX)) zc = ZW'(fbdp_pkg::Z_MAX);
    else                                 zc = z_w[NC];
    ph15   = 15'((zc + ZW'(128)) >>> 8);
    ph_mir = side_r[NC].re_neg ? OW'(fbdp_pkg::PHASE_HALF) - OW'(ph15) : OW'(ph15);
    ph_nxt = side_r[NC].im_neg ? -ph_mir : ph_mir;
  end

  always_ff @(posedge clk) begin
    prod_r <= lq * $signed(19'(fbdp_pkg::DB_PER_OCT_Q16));
    ph_r   <= ph_nxt;
  end

  // round half up, saturate
  always_comb begin
    lim_hi = PRW'(fbdp_pkg::LEVEL_MAX);
    lim_lo = PRW'(fbdp_pkg::LEVEL_MIN);
    rsum   = prod_r + PRW'(1 << 23);
    lvl    = rsum >>> 24;
    if (lvl > lim_hi)      lvl_nxt = OW'(fbdp_pkg::LEVEL_MAX);
    else if (lvl < lim_lo) lvl_nxt = OW'(fbdp_pkg::LEVEL_MIN);
    else                   lvl_nxt = lvl[OW-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    if (side_r[DEPTH-1].zero) begin
      out_level_db  <= OW'(fbdp_pkg::LEVEL_MIN);
      out_phase_deg <= '0;
    end else begin
      out_level_db  <= lvl_nxt;
      out_phase_deg <= ph_r;
    end
    out_zero_magnitude <= side_r[DEPTH-1].zero;
  end

  assign out_strobe = vld_r[DEPTH];

  // checks
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##23 out_strobe) else $error("result missing after fixed latency");

  a_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_zero_magnitude) |->
      (out_phase_deg == '0 && out_level_db == OW'(fbdp_pkg::LEVEL_MIN)))
    else $error("zero bin result wrong");

  a_phase_rng : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_phase_deg <= OW'(fbdp_pkg::PHASE_HALF) &&
                    out_phase_deg >= -OW'(fbdp_pkg::PHASE_HALF)))
    else $error("phase out of range");

endmodule
`default_nettype wire
